@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/wbps_pkg.sv @@
package wbps_pkg;

   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 64;
   localparam int CFG_W     = 64;
   localparam int CARE_W    = 16;
   localparam int LEN_W     = 5;
   localparam int CSR_IDX_W = 3;
   localparam int PAT_BYTES = 16;
   localparam int PAT_IDX_W = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_REGION_BASE    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic advance;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] addr;
   } result_type;

endpackage

@@ src/wildcard_byte_pattern_search.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_stall    req_data_byte, req_last_byte
// rsp       out        rsp_valid/rsp_stall    rsp_found, rsp_match_address
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One byte per cycle while req_stall is low: the window cells shift and compare in parallel until a hit.
// A result is registered in the output buffer's head or skid slot before it shows on rsp.
// Reset is synchronous; control and CSR registers come up at their reset values, no sweep; buffer data is not reset.
// Results queue in a two-entry output buffer; req_stall rises only when both are full.
module wildcard_byte_pattern_search
   import wbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [ADDR_W-1:0]    rsp_match_address,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam logic [LEN_W-1:0]       LEN_MAX    = LEN_W'(PATTERN_MAX);
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   logic [CFG_W-1:0]  pattern_low_ff;
   logic [CFG_W-1:0]  pattern_high_ff;
   logic [CARE_W-1:0] care_mask_ff;
   logic [LEN_W-1:0]  pattern_length_ff;
   logic [ADDR_W-1:0] region_base_ff;

   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   reported_ff, reported_in;

   logic [LEN_W-1:0]       len_eff;
   logic [OFFSET_BITS-1:0] offset_inc;
   logic [BYTE_W-1:0]      pattern_bytes [PAT_BYTES];
   logic [BYTE_W-1:0]      cell_bytes    [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_match;
   cell_ctrl_type          ctrl;
   logic                   accept;
   logic                   hit;
   logic                   push;
   logic                   buf_full;
   result_type             push_data;
   result_type             head_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '1;
         pattern_length_ff <= LEN_W'(1);
         region_base_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            CSR_CARE_MASK:      care_mask_ff      <= csr_data[CARE_W-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_W-1:0];
            CSR_REGION_BASE:    region_base_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pattern_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (pattern_length_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = pattern_length_ff;
      end
   end

   for (genvar b = 0; b < PAT_BYTES / 2; b++) begin : g_pat
      assign pattern_bytes[b]                 = pattern_low_ff[BYTE_W*b +: BYTE_W];
      assign pattern_bytes[b + PAT_BYTES / 2] = pattern_high_ff[BYTE_W*b +: BYTE_W];
   end

   assign accept       = req_valid && !req_stall;
   assign ctrl.advance = accept && !reported_ff;
   assign ctrl.clear   = accept && req_last_byte;

   // cell k holds the byte k positions back; it lines up with pattern byte len-1-k
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [LEN_W-1:0]  pat_idx;
      logic              in_use;
      logic [BYTE_W-1:0] byte_in;

      assign pat_idx = len_eff - LEN_W'(1) - LEN_W'(k);
      assign in_use  = LEN_W'(k) < len_eff;

      if (k == 0) begin : g_head
         assign byte_in = req_data_byte;
      end else begin : g_link
         assign byte_in = cell_bytes[k-1];
      end

      wbps_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .byte_in      (byte_in),
         .pattern_byte (pattern_bytes[pat_idx[PAT_IDX_W-1:0]]),
         .care         (in_use && care_mask_ff[pat_idx[PAT_IDX_W-1:0]]),
         .byte_out     (cell_bytes[k]),
         .match        (cell_match[k])
      );
   end

   assign offset_inc = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + OFFSET_BITS'(1);
   assign hit = ctrl.advance && (offset_inc >= OFFSET_BITS'(len_eff)) && (&cell_match);
   assign push = hit || (ctrl.advance && req_last_byte);

   always_comb begin
      push_data.found = hit;
      push_data.addr  = '0;
      if (hit) begin
         push_data.addr = region_base_ff + ADDR_W'(offset_inc - OFFSET_BITS'(len_eff));
      end
   end

   always_comb begin
      offset_in   = offset_ff;
      reported_in = reported_ff;
      if (ctrl.clear) begin
         offset_in   = '0;
         reported_in = 1'b0;
      end else if (ctrl.advance) begin
         offset_in   = offset_inc;
         reported_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         reported_ff <= 1'b0;
      end else begin
         offset_ff   <= offset_in;
         reported_ff <= reported_in;
      end
   end

   wbps_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (buf_full),
      .pop_stall  (rsp_stall),
      .head_valid (rsp_valid),
      .head_data  (head_data)
   );

   assign req_stall         = buf_full;
   assign rsp_found         = head_data.found;
   assign rsp_match_address = head_data.addr;

endmodule

@@ src/wbps_cell.sv @@
module wbps_cell
   import wbps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [BYTE_W-1:0] byte_in,
   input  logic [BYTE_W-1:0] pattern_byte,
   input  logic              care,
   output logic [BYTE_W-1:0] byte_out,
   output logic              match
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_next_in;

   // match is judged on the byte this cell holds after the shift
   assign match    = !care || (byte_in == pattern_byte);
   assign byte_out = byte_ff;

   always_comb begin
      byte_next_in = byte_ff;
      if (ctrl.clear) begin
         byte_next_in = '0;
      end else if (ctrl.advance) begin
         byte_next_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_next_in;
      end
   end

endmodule

@@ src/wbps_out_buf.sv @@
module wbps_out_buf
   import wbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   input  logic       pop_stall,
   output logic       head_valid,
   output result_type head_data
);

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop        = head_valid_ff && !pop_stall;
   assign full       = skid_valid_ff;
   assign head_valid = head_valid_ff;
   assign head_data  = head_ff;

   // push never arrives while the skid slot is occupied
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff) begin
         head_valid_in = push;
         head_in       = push_data;
      end else if (pop) begin
         head_valid_in = skid_valid_ff || push;
         head_in       = skid_valid_ff ? skid_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

@@ src/wbps_checker.sv @@
`include "assert_macros.svh"

module wbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [63:0] rsp_match_address
);

   `ASSERT_NEVER(a_nomatch_zero_addr, clock, reset, rsp_valid && !rsp_found && (rsp_match_address != 64'd0), "no-match result carries nonzero address")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_match_address), "stalled result changed")
   `ASSERT_CLK(a_stall_needs_backlog, clock, reset, $rose(req_stall) |-> $past(rsp_valid), "req stall without pending result")
   `ASSERT_CLK(a_rsp_needs_transfer, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall), "result without input transfer")

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (.*);
